// File: rtl/core/nsh_pkg.sv
`default_nettype none
package nsh_pkg;
  localparam int MAX_NGRAM_DEF  = 8;
  localparam int COUNT_BITS_DEF = 32;
  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  localparam logic [63:0] FNV_MUL   = 64'h00000100000001B3;
  localparam logic [63:0] MIX_K1    = 64'hFF51AFD7ED558CCD;
  localparam logic [63:0] MIX_K2    = 64'hC4CEB9FE1A85EC53;
  localparam logic [7:0]  SPACE_BYTE = 8'h20;
  localparam logic [3:0]  REG_NGRAM_SIZE = 4'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPACE,
    ST_BYTE,
    ST_END,
    ST_MIX,
    ST_COUNT,
    ST_TAIL,
    ST_VOTE,
    ST_OUT,
    ST_CLEAR
  } state_t;

  // multiplier operation requests
  typedef enum logic [1:0] {
    MOP_FNV,
    MOP_K1,
    MOP_K2
  } mop_t;

  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return x + (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1);
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/nsh_ram.sv
`default_nettype none
module nsh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/core/nsh_mul.sv
`default_nettype none
// 64x64 low product in three 32x32 partial products, one per cycle
module nsh_mul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      prod
);
  logic [63:0] a_r, b_r, acc_r, acc_nxt;
  logic [1:0]  step_r;
  logic        busy_r;
  logic [63:0] pp;
  always_comb begin
    pp = '0;
    case (step_r)
      2'd0: pp = a_r[31:0] * b_r[31:0];
      2'd1: pp = {a_r[63:32] * b_r[31:0], 32'd0};
      2'd2: pp = {a_r[31:0] * b_r[63:32], 32'd0};
      default: pp = '0;
    endcase
    acc_nxt = acc_r + pp;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd2) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end
  assign prod = acc_r;
endmodule
`default_nettype wire

// File: rtl/core/ngram_simhash_64.sv
`default_nettype none
// Streaming 64-bit SimHash over word n-grams (FNV-1a per gram, fmix64 finish).
// One text byte per beat; in_stall is high while a beat is in work, and for the
// clearing pass after reset. A byte inside a word runs the shift-add FNV update
// on each open gram (up to ngram_size, clamped to 1..MAX_NGRAM), a read and then
// a write of the gram accumulator RAM per gram; a space outside a word only
// passes the end check. A word start first folds the separating space into
// each earlier open gram. A word end that closes a gram reads it, runs the two
// partial-product multiplies of fmix64, then steps through the per-bit counter RAM.
// The end-of-text beat may add one more such feature for a short text, then a
// majority pass, the hand-over of the result beat (which waits while out_stall
// holds a previous result) and a clearing pass of the counter and gram RAMs
// before the next byte is taken.
module ngram_simhash_64
  import nsh_pkg::*;
#(
  parameter int MAX_NGRAM  = MAX_NGRAM_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_end_of_text,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_simhash,
  output logic [31:0]      out_feature_count,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int SW = (MAX_NGRAM > 1) ? $clog2(MAX_NGRAM) : 1;
  localparam int NW = $clog2(MAX_NGRAM + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  state_t state_r, state_nxt;
  logic [3:0] ngram_r;
  logic [7:0] byte_r;
  logic last_r;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [NW-1:0] begun_r, begun_nxt;
  logic inword_r, inword_nxt;
  logic [NW-1:0] k_r, k_nxt;
  logic phase_r, phase_nxt;
  logic [6:0] bit_r, bit_nxt;
  logic [63:0] v_r, v_nxt;
  logic [1:0] mstep_r, mstep_nxt;
  logic [COUNT_BITS-1:0] feat_r, feat_nxt;
  logic [63:0] hash_r, hash_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  // effective n
  logic [NW-1:0] n_eff;
  always_comb begin
    if (ngram_r == 4'd0) n_eff = NW'(1);
    else if (32'(ngram_r) > MAX_NGRAM) n_eff = NW'(MAX_NGRAM);
    else n_eff = NW'(ngram_r);
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {28'd0, ngram_r};
  always_ff @(posedge clk) begin
    if (!rst_n) ngram_r <= 4'd1;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_NGRAM_SIZE[1:0])
      ngram_r <= cfg_pwdata[3:0];
  end

  // gram ram
  logic g_we;
  logic [SW-1:0] g_wa, g_ra;
  logic [63:0] g_wd, g_rd;
  nsh_ram #(.WIDTH(64), .DEPTH(1 << SW)) u_gram (
    .clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd)
  );
  // counter ram
  logic c_we;
  logic [5:0] c_wa, c_ra;
  logic [COUNT_BITS-1:0] c_wd, c_rd;
  nsh_ram #(.WIDTH(COUNT_BITS), .DEPTH(64)) u_cnt (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd)
  );

  logic m_start, m_done;
  logic [63:0] m_a, m_b, m_p;
  nsh_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(m_start), .a(m_a), .b(m_b), .done(m_done), .prod(m_p)
  );

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  logic [SW-1:0] slot_fix;
  logic [NW-1:0] begun_fix;
  always_comb begin
    slot_fix  = (NW'(slot_r) >= n_eff) ? '0 : slot_r;
    begun_fix = (begun_r > n_eff) ? n_eff : begun_r;
  end

  always_comb begin
    state_nxt = state_r;
    slot_nxt = slot_r; begun_nxt = begun_r; inword_nxt = inword_r;
    k_nxt = k_r; phase_nxt = phase_r; bit_nxt = bit_r; v_nxt = v_r;
    mstep_nxt = mstep_r; feat_nxt = feat_r; hash_nxt = hash_r;
    out_valid_nxt = out_valid_r && out_stall;
    g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra = k_r[SW-1:0];
    c_we = 1'b0; c_wa = bit_r[5:0]; c_wd = '0; c_ra = bit_r[5:0];
    m_start = 1'b0; m_a = v_r; m_b = MIX_K1;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          slot_nxt = slot_fix;
          begun_nxt = begun_fix;
          k_nxt = '0; phase_nxt = 1'b0;
          if (in_text_byte != SPACE_BYTE && !inword_r) state_nxt = ST_SPACE;
          else if (in_text_byte != SPACE_BYTE) state_nxt = ST_BYTE;
          else state_nxt = ST_END;
        end
      end
      ST_SPACE: begin
        // phase 0 reads slot k, phase 1 writes its update
        if (k_r >= begun_r) begin
          g_we = 1'b1; g_wa = slot_r; g_wd = FNV_BASIS;
          slot_nxt = (NW'(slot_r) + NW'(1) >= n_eff) ? '0 : slot_r + SW'(1);
          if (begun_r < n_eff) begun_nxt = begun_r + NW'(1);
          inword_nxt = 1'b1;
          k_nxt = '0; phase_nxt = 1'b0;
          state_nxt = ST_BYTE;
        end else if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          g_we = 1'b1; g_wa = k_r[SW-1:0]; g_wd = fnv_step(g_rd, SPACE_BYTE);
          k_nxt = k_r + NW'(1); phase_nxt = 1'b0;
        end
      end
      ST_BYTE: begin
        if (k_r >= begun_r) begin
          k_nxt = '0; phase_nxt = 1'b0;
          state_nxt = ST_END;
        end else if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          g_we = 1'b1; g_wa = k_r[SW-1:0]; g_wd = fnv_step(g_rd, byte_r);
          k_nxt = k_r + NW'(1); phase_nxt = 1'b0;
        end
      end
      ST_END: begin
        g_ra = slot_r;
        if (inword_r && (byte_r == SPACE_BYTE || last_r)) begin
          if (begun_r >= n_eff) begin
            if (!phase_r) phase_nxt = 1'b1;
            else begin
              v_nxt = g_rd; mstep_nxt = '0; phase_nxt = 1'b0;
              state_nxt = ST_MIX;
            end
          end else begin
            inword_nxt = 1'b0;
            state_nxt = last_r ? ST_TAIL : ST_IDLE;
          end
          if (begun_r < n_eff) inword_nxt = 1'b0;
        end else begin
          state_nxt = last_r ? ST_TAIL : ST_IDLE;
        end
      end
      ST_MIX: begin
        // xorshift, multiply K1, xorshift, multiply K2, xorshift
        m_b = (mstep_r == 2'd0) ? MIX_K1 : MIX_K2;
        if (!phase_r) begin
          m_start = 1'b1;
          m_a = v_r ^ (v_r >> 33);
          phase_nxt = 1'b1;
        end else if (m_done) begin
          phase_nxt = 1'b0;
          if (mstep_r == 2'd0) begin
            v_nxt = m_p; mstep_nxt = 2'd1;
          end else begin
            v_nxt = m_p ^ (m_p >> 33);
            bit_nxt = '0;
            state_nxt = ST_COUNT;
          end
        end
      end
      ST_COUNT: begin
        if (bit_r[6]) begin
          if (feat_r != CMAX) feat_nxt = feat_r + COUNT_BITS'(1);
          if (inword_r) begin
            inword_nxt = 1'b0;
            state_nxt = last_r ? ST_TAIL : ST_IDLE;
          end else begin
            state_nxt = ST_VOTE; bit_nxt = '0; phase_nxt = 1'b0; hash_nxt = '0;
          end
        end else if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          c_we = v_r[bit_r[5:0]] && (c_rd != CMAX);
          c_wd = c_rd + COUNT_BITS'(1);
          bit_nxt = bit_r + 7'd1; phase_nxt = 1'b0;
        end
      end
      ST_TAIL: begin
        g_ra = '0;
        if (begun_r > '0 && begun_r < n_eff) begin
          if (!phase_r) phase_nxt = 1'b1;
          else begin
            v_nxt = g_rd; mstep_nxt = '0; phase_nxt = 1'b0;
            state_nxt = ST_MIX;
          end
        end else begin
          state_nxt = ST_VOTE; bit_nxt = '0; phase_nxt = 1'b0; hash_nxt = '0;
        end
      end
      ST_VOTE: begin
        if (bit_r[6]) begin
          state_nxt = ST_OUT;
        end else if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          hash_nxt[bit_r[5:0]] = (c_rd > (feat_r >> 1));
          bit_nxt = bit_r + 7'd1; phase_nxt = 1'b0;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          bit_nxt = '0;
          state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        // gram slots opened late after an n increase must read as zero
        c_we = 1'b1; c_wd = '0;
        g_we = 1'b1; g_wa = bit_r[SW-1:0]; g_wd = '0;
        bit_nxt = bit_r + 7'd1;
        if (bit_r[5:0] == 6'd63) begin
          feat_nxt = '0; slot_nxt = '0; begun_nxt = '0; inword_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      slot_r <= '0; begun_r <= '0; inword_r <= 1'b0;
      k_r <= '0; phase_r <= 1'b0; bit_r <= '0; mstep_r <= '0;
      feat_r <= '0; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r <= slot_nxt; begun_r <= begun_nxt; inword_r <= inword_nxt;
      k_r <= k_nxt; phase_r <= phase_nxt; bit_r <= bit_nxt; mstep_r <= mstep_nxt;
      feat_r <= feat_nxt; out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    hash_r <= hash_nxt;
    if (accept) begin
      byte_r <= in_text_byte;
      last_r <= in_end_of_text;
    end
    if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
      out_simhash <= hash_r;
      out_feature_count <= (COUNT_BITS > 32 && (feat_r >> 32) != '0) ? 32'hFFFFFFFF
                                                                    : 32'(feat_r);
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/nsh_checker.sv
`default_nettype none
module nsh_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [63:0] out_simhash,
  input wire logic [31:0] out_feature_count
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_simhash)) else $error("out held");
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("no stall after beat");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_feature_count == 32'd0 |-> out_simhash == 64'd0)
    else $error("empty text hash");
  a_no_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_stall) else $error("result outside text end");
endmodule

bind ngram_simhash_64 nsh_checker u_nsh_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_simhash(out_simhash), .out_feature_count(out_feature_count)
);
`default_nettype wire
